FILE: rtl/core/mcc_pkg.sv
// Shared types, codes and Morse lookup tables for the Morse code codec.
package mcc_pkg;

	typedef enum logic [1:0] {
		OP_ENCODE = 2'd0,
		OP_DOT    = 2'd1,
		OP_DASH   = 2'd2,
		OP_END    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		KIND_DOT    = 3'd0,
		KIND_DASH   = 3'd1,
		KIND_WORD   = 3'd2,
		KIND_NOCODE = 3'd3,
		KIND_CHAR   = 3'd4
	} kind_t;

	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam int unsigned SYM_W = 6;
	localparam int unsigned LEN_W = 3;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] char_in;
	} cmd_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] char_out;
		logic       last;
	} res_t;

	// Symbols are left aligned, first symbol in the top bit, 1 is a dash.
	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic [SYM_W-1:0] sym;
	} code_t;

	function automatic code_t enc_lookup(input logic [7:0] ch);
		logic [7:0] c;
		code_t      r;
		c = ch;
		// Fold lowercase onto uppercase and the extension pairs onto their first code.
		if (ch >= 8'h61 && ch <= 8'h7A) c = ch - 8'h20;
		if (ch == 8'h81) c = 8'h80;
		if (ch == 8'h83) c = 8'h82;
		unique case (c)
			8'h41: r = '{3'd2, 6'b010000};
			8'h42: r = '{3'd4, 6'b100000};
			8'h43: r = '{3'd4, 6'b101000};
			8'h44: r = '{3'd3, 6'b100000};
			8'h45: r = '{3'd1, 6'b000000};
			8'h46: r = '{3'd4, 6'b001000};
			8'h47: r = '{3'd3, 6'b110000};
			8'h48: r = '{3'd4, 6'b000000};
			8'h49: r = '{3'd2, 6'b000000};
			8'h4A: r = '{3'd4, 6'b011100};
			8'h4B: r = '{3'd3, 6'b101000};
			8'h4C: r = '{3'd4, 6'b010000};
			8'h4D: r = '{3'd2, 6'b110000};
			8'h4E: r = '{3'd2, 6'b100000};
			8'h4F: r = '{3'd3, 6'b111000};
			8'h50: r = '{3'd4, 6'b011000};
			8'h51: r = '{3'd4, 6'b110100};
			8'h52: r = '{3'd3, 6'b010000};
			8'h53: r = '{3'd3, 6'b000000};
			8'h54: r = '{3'd1, 6'b100000};
			8'h55: r = '{3'd3, 6'b001000};
			8'h56: r = '{3'd4, 6'b000100};
			8'h57: r = '{3'd3, 6'b011000};
			8'h58: r = '{3'd4, 6'b100100};
			8'h59: r = '{3'd4, 6'b101100};
			8'h5A: r = '{3'd4, 6'b110000};
			8'h30: r = '{3'd5, 6'b111110};
			8'h31: r = '{3'd5, 6'b011110};
			8'h32: r = '{3'd5, 6'b001110};
			8'h33: r = '{3'd5, 6'b000110};
			8'h34: r = '{3'd5, 6'b000010};
			8'h35: r = '{3'd5, 6'b000000};
			8'h36: r = '{3'd5, 6'b100000};
			8'h37: r = '{3'd5, 6'b110000};
			8'h38: r = '{3'd5, 6'b111000};
			8'h39: r = '{3'd5, 6'b111100};
			8'h21: r = '{3'd6, 6'b101011};
			8'h22: r = '{3'd6, 6'b010010};
			8'h26: r = '{3'd5, 6'b010000};
			8'h27: r = '{3'd6, 6'b011110};
			8'h28: r = '{3'd5, 6'b101100};
			8'h29: r = '{3'd6, 6'b101101};
			8'h2B: r = '{3'd5, 6'b010100};
			8'h2C: r = '{3'd6, 6'b110011};
			8'h2D: r = '{3'd6, 6'b100001};
			8'h2E: r = '{3'd6, 6'b010101};
			8'h2F: r = '{3'd5, 6'b100100};
			8'h3A: r = '{3'd6, 6'b111000};
			8'h3B: r = '{3'd6, 6'b101010};
			8'h3D: r = '{3'd5, 6'b100010};
			8'h3F: r = '{3'd6, 6'b001100};
			8'h40: r = '{3'd6, 6'b011010};
			8'h80: r = '{3'd5, 6'b110110};
			8'h82: r = '{3'd5, 6'b101000};
			default: r = '{3'd0, 6'b000000};
		endcase
		return r;
	endfunction

	// Index of a code is (2**len - 1) plus its symbols read as a binary number.
	function automatic logic [7:0] dec_lookup(input logic [7:0] idx);
		logic [7:0] r;
		unique case (idx)
			8'd1:   r = 8'h45;
			8'd2:   r = 8'h54;
			8'd3:   r = 8'h49;
			8'd4:   r = 8'h41;
			8'd5:   r = 8'h4E;
			8'd6:   r = 8'h4D;
			8'd7:   r = 8'h53;
			8'd8:   r = 8'h55;
			8'd9:   r = 8'h52;
			8'd10:  r = 8'h57;
			8'd11:  r = 8'h44;
			8'd12:  r = 8'h4B;
			8'd13:  r = 8'h47;
			8'd14:  r = 8'h4F;
			8'd15:  r = 8'h48;
			8'd16:  r = 8'h56;
			8'd17:  r = 8'h46;
			8'd19:  r = 8'h4C;
			8'd21:  r = 8'h50;
			8'd22:  r = 8'h4A;
			8'd23:  r = 8'h42;
			8'd24:  r = 8'h58;
			8'd25:  r = 8'h43;
			8'd26:  r = 8'h59;
			8'd27:  r = 8'h5A;
			8'd28:  r = 8'h51;
			8'd31:  r = 8'h35;
			8'd32:  r = 8'h34;
			8'd34:  r = 8'h33;
			8'd38:  r = 8'h32;
			8'd39:  r = 8'h26;
			8'd41:  r = 8'h2B;
			8'd46:  r = 8'h31;
			8'd47:  r = 8'h36;
			8'd48:  r = 8'h3D;
			8'd49:  r = 8'h2F;
			8'd51:  r = 8'h82;
			8'd53:  r = 8'h28;
			8'd55:  r = 8'h37;
			8'd58:  r = 8'h80;
			8'd59:  r = 8'h38;
			8'd61:  r = 8'h39;
			8'd62:  r = 8'h30;
			8'd75:  r = 8'h3F;
			8'd81:  r = 8'h22;
			8'd84:  r = 8'h2E;
			8'd89:  r = 8'h40;
			8'd93:  r = 8'h27;
			8'd96:  r = 8'h2D;
			8'd105: r = 8'h3B;
			8'd106: r = 8'h21;
			8'd108: r = 8'h29;
			8'd114: r = 8'h2C;
			8'd119: r = 8'h3A;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/core/morse_code_codec.sv
// Morse code codec top level: command intake, symbol shifter, index fold and result register.
//
// Usage:
//   cmd channel (cmd_valid / cmd_ready / cmd) takes one beat per command:
//   encode a character, fold a dot, fold a dash, or end a character.
//   res channel (res_valid / res_ready / res) gives result beats, each with
//   a kind, a decoded character and a last flag on the final beat of a command.
//   Encode shifts the code out of a 6-bit register one symbol per cycle while
//   the result register has room, one beat per code symbol; space, no-code
//   and end of character give a single beat; a dot or dash folds into the
//   8-bit sequence index in the accept cycle and yields no beat. An encode or
//   end command is registered into the sequencer state, and its beats then
//   pass through the result register. The next command is taken in the cycle
//   the last result of the current one enters the result register, so beats
//   of back-to-back commands follow with no gap while the receiver keeps up;
//   dot and dash go one per cycle while the sequencer is idle. Reset clears
//   the sequence index, the sequencer and the result valid. On a receiver
//   stall the result register keeps its beat and the shifter its place, and
//   one more encode or end command can be taken once the sequencer is idle.
module morse_code_codec (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  mcc_pkg::cmd_t  cmd,
	output logic           res_valid,
	input  logic           res_ready,
	output mcc_pkg::res_t  res
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SYM    = 5'b00010,
		ST_WORD   = 5'b00100,
		ST_NOCODE = 5'b01000,
		ST_CHAR   = 5'b10000
	} state_t;

	state_t                          state_q;
	logic [mcc_pkg::SYM_W-1:0]       sym_q;
	logic [mcc_pkg::LEN_W-1:0]       cnt_q;
	logic [7:0]                      idx_q;
	logic [7:0]                      char_q;
	logic                            res_valid_q;
	mcc_pkg::res_t                   res_q;

	logic            cmd_acc;
	logic            emit;
	logic            fin;
	mcc_pkg::res_t   res_nxt;
	mcc_pkg::code_t  code;

	assign code = mcc_pkg::enc_lookup(cmd.char_in);

	// Load the result register whenever there is a pending beat and room for it.
	assign emit = (state_q != ST_IDLE) && (!res_valid_q || res_ready);
	assign fin  = emit && ((state_q != ST_SYM) || (cnt_q == mcc_pkg::LEN_W'(1)));

	assign cmd_ready = (state_q == ST_IDLE) || fin;
	assign cmd_acc   = cmd_valid && cmd_ready;

	always_comb begin
		res_nxt = '{kind: mcc_pkg::KIND_NOCODE, char_out: 8'h00, last: 1'b1};
		unique case (state_q)
			ST_SYM: begin
				res_nxt.kind = sym_q[mcc_pkg::SYM_W-1] ? mcc_pkg::KIND_DASH : mcc_pkg::KIND_DOT;
				res_nxt.last = (cnt_q == mcc_pkg::LEN_W'(1));
			end
			ST_WORD: begin
				res_nxt.kind = mcc_pkg::KIND_WORD;
			end
			ST_CHAR: begin
				res_nxt.kind     = mcc_pkg::KIND_CHAR;
				res_nxt.char_out = char_q;
			end
			ST_NOCODE, ST_IDLE: begin
				res_nxt.kind = mcc_pkg::KIND_NOCODE;
			end
			default: begin
				res_nxt.kind = mcc_pkg::KIND_NOCODE;
			end
		endcase
	end

	// Sequencer, symbol counter and sequence index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			idx_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end

			// Advance the current command; drop to idle on its last beat.
			if (fin) begin
				state_q <= ST_IDLE;
			end
			if (emit && state_q == ST_SYM) begin
				cnt_q <= cnt_q - mcc_pkg::LEN_W'(1);
			end

			// A new command overrides the idle drop above.
			if (cmd_acc) begin
				unique case (mcc_pkg::op_t'(cmd.operation))
					mcc_pkg::OP_ENCODE: begin
						if (cmd.char_in == mcc_pkg::CHAR_SPACE) begin
							state_q <= ST_WORD;
						end else if (code.len == '0) begin
							state_q <= ST_NOCODE;
						end else begin
							state_q <= ST_SYM;
							cnt_q   <= code.len;
						end
					end
					mcc_pkg::OP_DOT: begin
						idx_q <= {idx_q[6:0], 1'b0} + 8'd1;
					end
					mcc_pkg::OP_DASH: begin
						idx_q <= {idx_q[6:0], 1'b0} + 8'd2;
					end
					mcc_pkg::OP_END: begin
						state_q <= ST_CHAR;
						idx_q   <= '0;
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

	// Payload: symbol shifter, decoded character and result register.
	always_ff @(posedge clk) begin
		if (emit && state_q == ST_SYM) begin
			sym_q <= {sym_q[mcc_pkg::SYM_W-2:0], 1'b0};
		end
		if (cmd_acc && cmd.operation == mcc_pkg::OP_ENCODE) begin
			sym_q <= code.sym;
		end
		if (cmd_acc && cmd.operation == mcc_pkg::OP_END) begin
			char_q <= mcc_pkg::dec_lookup(idx_q);
		end
		if (emit) begin
			res_q <= res_nxt;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// A symbol run always has symbols left to send.
	a_sym_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SYM) |-> (cnt_q != '0))
		else $error("symbol state with empty counter");

	// A decoded character is always the only and final beat of its command.
	a_char_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.kind == mcc_pkg::KIND_CHAR) |-> res.last)
		else $error("decoded character without last");

	// Only decoded characters carry a character byte.
	a_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.kind != mcc_pkg::KIND_CHAR) |-> (res.char_out == 8'h00))
		else $error("nonzero character on a non-character beat");

	// A folded symbol leaves the sequencer idle.
	a_fold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_acc && (cmd.operation == mcc_pkg::OP_DOT || cmd.operation == mcc_pkg::OP_DASH))
		|=> (state_q == ST_IDLE))
		else $error("fold left sequencer busy");

	// End of character clears the sequence index.
	a_end_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_acc && cmd.operation == mcc_pkg::OP_END) |=> (idx_q == 8'h00))
		else $error("index not cleared after end of character");

endmodule

FILE: tb/sv/tb_morse_code_codec.sv
// Testbench for the Morse code codec: random and directed commands checked against a local model.
`timescale 1ns / 100ps

module tb_morse_code_codec;

	localparam int  CYCLE_LIMIT  = 200000;
	localparam int  RANDOM_CMDS  = 320;
	localparam int  DRAIN_CYCLES = 12;
	localparam byte DASH_MARK    = "-";

	logic          clk;
	logic          arst_n    = 1'b0;
	logic          cmd_valid = 1'b0;
	logic          cmd_ready;
	mcc_pkg::cmd_t cmd       = '0;
	logic          res_valid;
	logic          res_ready = 1'b0;
	mcc_pkg::res_t res;

	// Commands waiting for the driver, and result beats owed by the block.
	mcc_pkg::cmd_t pending_cmds[$];
	mcc_pkg::res_t beats_due[$];

	// Local copy of the decode state and the reverse code table.
	logic [7:0] seq_index = 8'h00;
	logic [7:0] char_of_index [256];

	int   total_cmds    = 0;
	int   cmds_accepted = 0;
	int   beats_seen    = 0;
	int   mismatches    = 0;
	int   cycles        = 0;
	int   op_count [4];
	int   kind_count [5];
	logic cmd_beat      = 1'b0;

	// Driver pacing: bursts and gaps on the command side, stall modes on the result side.
	int   burst_left  = 6;
	int   gap_left    = 0;
	int   stall_mode  = 0;
	int   stall_left  = 40;
	int   stall_phase = 0;
	logic [7:0] stall_pattern = 8'hA5;

	morse_code_codec u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Dot-dash spelling of a character; empty when the character has no code.
	// Lowercase shares the uppercase code, and each extension pair shares one code.
	function automatic string morse_pattern(input logic [7:0] ch);
		logic [7:0] c;
		string      s;
		c = ch;
		if (ch >= 8'h61 && ch <= 8'h7A) c = ch - 8'h20;
		if (ch == 8'h81) c = 8'h80;
		if (ch == 8'h83) c = 8'h82;
		case (c)
			8'h21: s = "-.-.--";
			8'h22: s = ".-..-.";
			8'h26: s = ".-...";
			8'h27: s = ".----.";
			8'h28: s = "-.--.";
			8'h29: s = "-.--.-";
			8'h2B: s = ".-.-.";
			8'h2C: s = "--..--";
			8'h2D: s = "-....-";
			8'h2E: s = ".-.-.-";
			8'h2F: s = "-..-.";
			8'h30: s = "-----";
			8'h31: s = ".----";
			8'h32: s = "..---";
			8'h33: s = "...--";
			8'h34: s = "....-";
			8'h35: s = ".....";
			8'h36: s = "-....";
			8'h37: s = "--...";
			8'h38: s = "---..";
			8'h39: s = "----.";
			8'h3A: s = "---...";
			8'h3B: s = "-.-.-.";
			8'h3D: s = "-...-";
			8'h3F: s = "..--..";
			8'h40: s = ".--.-.";
			8'h41: s = ".-";
			8'h42: s = "-...";
			8'h43: s = "-.-.";
			8'h44: s = "-..";
			8'h45: s = ".";
			8'h46: s = "..-.";
			8'h47: s = "--.";
			8'h48: s = "....";
			8'h49: s = "..";
			8'h4A: s = ".---";
			8'h4B: s = "-.-";
			8'h4C: s = ".-..";
			8'h4D: s = "--";
			8'h4E: s = "-.";
			8'h4F: s = "---";
			8'h50: s = ".--.";
			8'h51: s = "--.-";
			8'h52: s = ".-.";
			8'h53: s = "...";
			8'h54: s = "-";
			8'h55: s = "..-";
			8'h56: s = "...-";
			8'h57: s = ".--";
			8'h58: s = "-..-";
			8'h59: s = "-.--";
			8'h5A: s = "--..";
			8'h80: s = "--.--";
			8'h82: s = "-.-..";
			default: s = "";
		endcase
		return s;
	endfunction

	// Fold one symbol into the index: times two, plus one for a dot or two for a dash.
	function automatic logic [7:0] fold_symbol(input logic [7:0] idx, input logic dash);
		return {idx[6:0], 1'b0} + (dash ? 8'd2 : 8'd1);
	endfunction

	function automatic logic [7:0] pick_coded_char();
		logic [7:0] ch;
		ch = 8'($urandom_range(0, 255));
		while (morse_pattern(ch).len() == 0)
			ch = 8'($urandom_range(0, 255));
		return ch;
	endfunction

	task automatic add_cmd(input mcc_pkg::op_t op, input logic [7:0] ch);
		mcc_pkg::cmd_t c;
		c.operation = op;
		c.char_in   = ch;
		pending_cmds.push_back(c);
		total_cmds++;
	endtask

	// Spell a character as dot and dash commands followed by end of character.
	task automatic add_spelling(input string pat);
		int i;
		for (i = 0; i < pat.len(); i++)
			add_cmd(pat[i] == DASH_MARK ? mcc_pkg::OP_DASH : mcc_pkg::OP_DOT,
				8'($urandom_range(0, 255)));
		add_cmd(mcc_pkg::OP_END, 8'($urandom_range(0, 255)));
	endtask

	// Work out the beats one accepted command owes and advance the decode state.
	task automatic emit_morse_beats(input mcc_pkg::cmd_t c);
		string         pat;
		mcc_pkg::res_t r;
		int            i;
		pat = morse_pattern(c.char_in);
		r   = '0;
		op_count[c.operation]++;
		case (mcc_pkg::op_t'(c.operation))
			mcc_pkg::OP_ENCODE: begin
				if (c.char_in == mcc_pkg::CHAR_SPACE) begin
					r.kind = mcc_pkg::KIND_WORD;
					r.last = 1'b1;
					beats_due.push_back(r);
				end else if (pat.len() == 0) begin
					r.kind = mcc_pkg::KIND_NOCODE;
					r.last = 1'b1;
					beats_due.push_back(r);
				end else begin
					for (i = 0; i < pat.len(); i++) begin
						r.kind = (pat[i] == DASH_MARK) ? mcc_pkg::KIND_DASH : mcc_pkg::KIND_DOT;
						r.last = (i == pat.len() - 1);
						beats_due.push_back(r);
					end
				end
			end
			mcc_pkg::OP_DOT:  seq_index = fold_symbol(seq_index, 1'b0);
			mcc_pkg::OP_DASH: seq_index = fold_symbol(seq_index, 1'b1);
			mcc_pkg::OP_END: begin
				r.kind     = mcc_pkg::KIND_CHAR;
				r.char_out = char_of_index[seq_index];
				r.last     = 1'b1;
				beats_due.push_back(r);
				seq_index = 8'h00;
			end
		endcase
	endtask

	task automatic note_failure(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("[%0t] result beat %0d: %s", $realtime, beats_seen, msg);
	endtask

	// Compare one result beat with the oldest owed beat, field by field.
	task automatic check_beat(input mcc_pkg::res_t got);
		mcc_pkg::res_t want;
		if (got.kind <= mcc_pkg::KIND_CHAR) kind_count[got.kind]++;
		if (beats_due.size() == 0) begin
			note_failure($sformatf("unexpected beat kind %0d char %02h last %0d",
				got.kind, got.char_out, got.last));
		end else begin
			want = beats_due.pop_front();
			if (got.kind !== want.kind || got.char_out !== want.char_out ||
			    got.last !== want.last)
				note_failure($sformatf(
					"expected kind %0d char %02h last %0d, got kind %0d char %02h last %0d",
					want.kind, want.char_out, want.last, got.kind, got.char_out, got.last));
		end
		beats_seen++;
	endtask

	// Monitor: sample both handshakes at the rising edge. Check first so that a
	// command accepted on this edge never lines up against an older beat.
	always @(posedge clk) begin
		if (arst_n) begin
			cmd_beat <= cmd_valid && cmd_ready;
			if (res_valid && res_ready)
				check_beat(res);
			if (cmd_valid && cmd_ready) begin
				emit_morse_beats(cmd);
				cmds_accepted++;
			end
		end
	end

	// Driver: change inputs on the falling edge only.
	always @(negedge clk) begin
		if (arst_n) begin
			// Hold the current beat until it is taken, then advance or go idle.
			if (!cmd_valid || cmd_beat) begin
				if (gap_left > 0 || pending_cmds.size() == 0) begin
					cmd_valid <= 1'b0;
					if (gap_left > 0) gap_left--;
				end else begin
					cmd       <= pending_cmds.pop_front();
					cmd_valid <= 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 24);
						// Leave a third of the bursts back to back with the next.
						case ($urandom_range(0, 2))
							0:       gap_left = 0;
							1:       gap_left = $urandom_range(1, 3);
							default: gap_left = $urandom_range(1, 12);
						endcase
					end
				end
			end

			// Receiver: switch to a new random stall mode when the current one runs out.
			if (stall_left == 0) begin
				stall_mode    = $urandom_range(0, 3);
				stall_left    = $urandom_range(16, 80);
				stall_pattern = 8'($urandom_range(1, 255));
			end else begin
				stall_left--;
			end
			stall_phase = (stall_phase + 1) % 8;
			case (stall_mode)
				0:       res_ready <= 1'b1;
				1:       res_ready <= ($urandom_range(0, 3) != 0);
				2:       res_ready <= stall_pattern[3'(stall_phase)];
				default: res_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// Watchdog: end a hung run.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d beats still owed", cycles, beats_due.size());
			$display("tb_morse_code_codec failed");
			$finish;
		end
	end

	initial begin
		int    n;
		int    i;
		int    k;
		int    pick;
		int    run;
		string pat;

		// Reverse table: walk downward so the lowest character wins a shared code.
		for (n = 0; n < 256; n++) char_of_index[8'(n)] = 8'h00;
		for (n = 255; n >= 0; n--) begin
			pat = morse_pattern(8'(n));
			if (pat.len() != 0) begin
				k = 0;
				for (i = 0; i < pat.len(); i++)
					k = fold_symbol(8'(k), pat[i] == DASH_MARK);
				char_of_index[8'(k)] = 8'(n);
			end
		end
		for (n = 0; n < 4; n++) op_count[2'(n)] = 0;
		for (n = 0; n < 5; n++) kind_count[3'(n)] = 0;

		// Directed: byte extremes, space, six-symbol codes, extension pairs, no-code bytes.
		add_cmd(mcc_pkg::OP_ENCODE, 8'h00);
		add_cmd(mcc_pkg::OP_ENCODE, 8'hFF);
		add_cmd(mcc_pkg::OP_ENCODE, mcc_pkg::CHAR_SPACE);
		add_cmd(mcc_pkg::OP_ENCODE, 8'h41);
		add_cmd(mcc_pkg::OP_ENCODE, 8'h7A);
		add_cmd(mcc_pkg::OP_ENCODE, 8'h30);
		add_cmd(mcc_pkg::OP_ENCODE, 8'h2C);
		add_cmd(mcc_pkg::OP_ENCODE, 8'h21);
		add_cmd(mcc_pkg::OP_ENCODE, 8'h80);
		add_cmd(mcc_pkg::OP_ENCODE, 8'h81);
		add_cmd(mcc_pkg::OP_ENCODE, 8'h83);
		add_cmd(mcc_pkg::OP_ENCODE, 8'h7F);
		add_cmd(mcc_pkg::OP_ENCODE, 8'h3C);
		// End of character with nothing folded in.
		add_cmd(mcc_pkg::OP_END, 8'hFF);
		// Dot then dash with the ignored byte in both alternating bit patterns.
		add_cmd(mcc_pkg::OP_DOT, 8'h55);
		add_cmd(mcc_pkg::OP_DASH, 8'hAA);
		add_cmd(mcc_pkg::OP_END, 8'h00);
		// Long dash run: the index wraps and lands on an unknown sequence.
		for (i = 0; i < 8; i++) add_cmd(mcc_pkg::OP_DASH, 8'($urandom_range(0, 255)));
		add_cmd(mcc_pkg::OP_END, 8'h00);

		// Random: mostly clean spellings and encodes, some broken runs and noise.
		n = 0;
		while (n < RANDOM_CMDS) begin
			k    = total_cmds;
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				case ($urandom_range(0, 9))
					0:       add_cmd(mcc_pkg::OP_ENCODE, mcc_pkg::CHAR_SPACE);
					1, 2:    add_cmd(mcc_pkg::OP_ENCODE, 8'($urandom_range(0, 255)));
					default: add_cmd(mcc_pkg::OP_ENCODE, pick_coded_char());
				endcase
			end else if (pick < 80) begin
				add_spelling(morse_pattern(pick_coded_char()));
			end else if (pick < 90) begin
				// Broken sequence: arbitrary symbols, sometimes long enough to wrap.
				run = $urandom_range(0, 12);
				for (i = 0; i < run; i++)
					add_cmd($urandom_range(0, 1) ? mcc_pkg::OP_DASH : mcc_pkg::OP_DOT,
						8'($urandom_range(0, 255)));
				add_cmd(mcc_pkg::OP_END, 8'($urandom_range(0, 255)));
			end else begin
				add_cmd(mcc_pkg::op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
			end
			n += total_cmds - k;
		end

		// Hold reset, then release it on a falling edge.
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (cmds_accepted < total_cmds) @(posedge clk);
		while (beats_due.size() != 0) @(posedge clk);
		// Give stray beats a chance to show up.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (beats_due.size() != 0)
			note_failure($sformatf("%0d beats never arrived", beats_due.size()));

		$display("covered %0d commands: %0d encode, %0d dot, %0d dash, %0d end of character",
			cmds_accepted, op_count[mcc_pkg::OP_ENCODE], op_count[mcc_pkg::OP_DOT],
			op_count[mcc_pkg::OP_DASH], op_count[mcc_pkg::OP_END]);
		$display("checked %0d beats: %0d dot, %0d dash, %0d word, %0d no code, %0d char; %0d bad",
			beats_seen, kind_count[mcc_pkg::KIND_DOT], kind_count[mcc_pkg::KIND_DASH],
			kind_count[mcc_pkg::KIND_WORD], kind_count[mcc_pkg::KIND_NOCODE],
			kind_count[mcc_pkg::KIND_CHAR], mismatches);
		if (mismatches == 0)
			$display("tb_morse_code_codec passed");
		else
			$display("tb_morse_code_codec failed");
		$finish;
	end

endmodule
